[src/fbwc_pkg.sv]
// Shared types and constants for the flash block write-back cache.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package fbwc_pkg;

    localparam int FBWC_WAYS              = 8;
    localparam int FBWC_NUM_BLOCKS        = 2048;
    localparam int FBWC_SECTORS_PER_BLOCK = 8;

    localparam int BLOCK_W   = 11;
    localparam int SECTOR_W  = 3;
    localparam int COUNT_W   = 4;
    localparam int OP_W      = 2;
    localparam int WAY_OUT_W = 3;
    localparam int MARK_W    = 15;

    localparam logic [31:0] MARK_MAX = 32'h0000_7FFF;

    typedef enum logic [OP_W-1:0] {
        OP_FILL      = 2'd0,
        OP_WRITEBACK = 2'd1,
        OP_STORE     = 2'd2,
        OP_DONE      = 2'd3
    } op_t;

    // What the datapath places in the output register when the controller emits.
    typedef enum logic [2:0] {
        ACT_EVICT,
        ACT_FILL,
        ACT_STORE,
        ACT_FULL,
        ACT_FLUSH_WB,
        ACT_DONE
    } act_t;

    typedef struct packed {
        logic take;
        logic commit;
        logic emit;
        act_t act;
        logic last;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic drop;
        logic hit;
        logic has_free;
        logic victim_dirty;
        logic full_run;
        logic flush_pending;
        logic slot_free;
    } dp_status_t;

endpackage

[src/fbwc_if.sv]
// Request and result channel interfaces of the flash block write-back cache.
// Depends on fbwc_pkg for the field widths.
interface fbwc_req_if import fbwc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [BLOCK_W-1:0]  block;
    logic [SECTOR_W-1:0] first_sector;
    logic [COUNT_W-1:0]  sector_count;

    modport source (output valid, kind, block, first_sector, sector_count, input ready);
    modport sink (input valid, kind, block, first_sector, sector_count, output ready);
endinterface

interface fbwc_rsp_if import fbwc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [WAY_OUT_W-1:0] way;
    logic [BLOCK_W-1:0]   flash_block;
    logic [SECTOR_W-1:0]  start_sector;
    logic [COUNT_W-1:0]   run_length;
    logic [MARK_W-1:0]    high_water;
    logic                 last;

    modport source (output valid, op, way, flash_block, start_sector, run_length,
                    high_water, last, input ready);
    modport sink (input valid, op, way, flash_block, start_sector, run_length,
                  high_water, last, output ready);
endinterface

[src/fbwc_ctrl.sv]
// Controller state machine of the flash block write-back cache.
// Sequences lookup, eviction, fill, store and flush; depends on fbwc_pkg.
module fbwc_ctrl import fbwc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EVICT,
        S_FILL,
        S_STORE,
        S_FULL,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '{take: 1'b0, commit: 1'b0, emit: 1'b0, act: ACT_DONE, last: 1'b0};
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (status.is_flush)
                begin
                    state_next = S_FLUSH;
                end
                else if (status.drop)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    if (status.hit)
                        state_next = S_STORE;
                    else if (status.has_free || !status.victim_dirty)
                        state_next = S_FILL;
                    else
                        state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                cmd.act  = ACT_EVICT;
                cmd.emit = status.slot_free;
                if (status.slot_free)
                    state_next = S_FILL;
            end
            S_FILL:
            begin
                cmd.act  = ACT_FILL;
                cmd.emit = status.slot_free;
                if (status.slot_free)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.act  = ACT_STORE;
                cmd.last = !status.full_run;
                cmd.emit = status.slot_free;
                if (status.slot_free)
                    state_next = status.full_run ? S_FULL : S_IDLE;
            end
            S_FULL:
            begin
                cmd.act  = ACT_FULL;
                cmd.last = 1'b1;
                cmd.emit = status.slot_free;
                if (status.slot_free)
                    state_next = S_IDLE;
            end
            S_FLUSH:
            begin
                // One dirty way is written back per result; done comes when none is left.
                cmd.act  = status.flush_pending ? ACT_FLUSH_WB : ACT_DONE;
                cmd.last = !status.flush_pending;
                cmd.emit = status.slot_free;
                if (status.slot_free && !status.flush_pending)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[src/fbwc_datapath.sv]
// Datapath of the flash block write-back cache: tag store, valid and dirty bits,
// round-robin counter, high-water mark and the result register. Depends on fbwc_pkg.
module fbwc_datapath import fbwc_pkg::*;
#(
    parameter int WAYS              = FBWC_WAYS,
    parameter int NUM_BLOCKS        = FBWC_NUM_BLOCKS,
    parameter int SECTORS_PER_BLOCK = FBWC_SECTORS_PER_BLOCK
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                kind,
    input  logic [BLOCK_W-1:0]  block,
    input  logic [SECTOR_W-1:0] first_sector,
    input  logic [COUNT_W-1:0]  sector_count,
    input  ctl_cmd_t            cmd,
    output dp_status_t          status,
    fbwc_rsp_if.source          rsp
);

    localparam int WAY_W = $clog2(WAYS);

    function automatic logic [WAY_W-1:0] first_set(input logic [WAYS-1:0] vec);
        logic [WAY_W-1:0] idx;
        idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vec[w])
                idx = WAY_W'(w);
        end
        return idx;
    endfunction

    function automatic logic [WAY_OUT_W-1:0] way_out(input logic [WAY_W-1:0] idx);
        logic [WAY_W+WAY_OUT_W-1:0] ext;
        ext = {{WAY_OUT_W{1'b0}}, idx};
        return ext[WAY_OUT_W-1:0];
    endfunction

    // Latched input item.
    logic                kind_reg;
    logic [BLOCK_W-1:0]  blk_reg;
    logic [SECTOR_W-1:0] fs_reg;
    logic [COUNT_W-1:0]  cnt_reg;

    logic [BLOCK_W-1:0]  tags_reg [WAYS];
    logic [WAYS-1:0]     valid_reg, valid_next;
    logic [WAYS-1:0]     dirty_reg, dirty_next;
    logic [WAY_W-1:0]    rot_reg, rot_next;
    logic [WAY_W-1:0]    sel_reg, sel_next;
    logic [MARK_W-1:0]   mark_reg, mark_next;

    // Result register.
    logic                 rv_reg, rv_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [WAY_OUT_W-1:0] way_reg, way_next;
    logic [BLOCK_W-1:0]   fblk_reg, fblk_next;
    logic [SECTOR_W-1:0]  start_reg, start_next;
    logic [COUNT_W-1:0]   run_reg, run_next;
    logic [MARK_W-1:0]    hw_reg, hw_next;
    logic                 last_reg, last_next;

    logic [7:0]         room;
    logic [COUNT_W-1:0] cnt_eff;
    logic               fs_bad, blk_bad;
    logic [WAYS-1:0]    match, flush_mask;
    logic [WAY_W-1:0]   hit_way, free_way, flush_way, rd_idx;
    logic [BLOCK_W-1:0] rd_tag;
    logic [31:0]        run_end, run_end_sat;
    logic [MARK_W-1:0]  mark_cand;
    logic               slot_free;

    assign room    = 8'(SECTORS_PER_BLOCK) - {5'b0, fs_reg};
    assign cnt_eff = ({4'b0, cnt_reg} > room) ? room[COUNT_W-1:0] : cnt_reg;
    assign fs_bad  = {5'b0, fs_reg} >= 8'(SECTORS_PER_BLOCK);
    assign blk_bad = {21'b0, blk_reg} >= 32'(NUM_BLOCKS);

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
            match[w] = valid_reg[w] && (tags_reg[w] == blk_reg);
    end

    assign flush_mask = valid_reg & dirty_reg;
    assign hit_way    = first_set(match);
    assign free_way   = first_set(~valid_reg);
    assign flush_way  = first_set(flush_mask);

    // Single tag read port: the flush scan or the selected way.
    assign rd_idx = (cmd.act == ACT_FLUSH_WB) ? flush_way : sel_reg;
    assign rd_tag = tags_reg[rd_idx];

    assign run_end     = {21'b0, blk_reg} * 32'(SECTORS_PER_BLOCK)
                       + {29'b0, fs_reg} + {28'b0, cnt_eff};
    assign run_end_sat = (run_end > MARK_MAX) ? MARK_MAX : run_end;
    assign mark_cand   = run_end_sat[MARK_W-1:0];

    assign slot_free = !rv_reg || rsp.ready;

    assign status.is_flush      = kind_reg;
    assign status.drop          = blk_bad || fs_bad || (cnt_eff == '0);
    assign status.hit           = |match;
    assign status.has_free      = ~&valid_reg;
    assign status.victim_dirty  = dirty_reg[rot_reg];
    assign status.full_run      = {4'b0, cnt_eff} == 8'(SECTORS_PER_BLOCK);
    assign status.flush_pending = |flush_mask;
    assign status.slot_free     = slot_free;

    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        rot_next   = rot_reg;
        sel_next   = sel_reg;
        mark_next  = mark_reg;
        rv_next    = rv_reg && !rsp.ready;
        op_next    = op_reg;
        way_next   = way_reg;
        fblk_next  = fblk_reg;
        start_next = start_reg;
        run_next   = run_reg;
        hw_next    = hw_reg;
        last_next  = last_reg;

        if (cmd.commit)
        begin
            if (status.hit)
                sel_next = hit_way;
            else if (status.has_free)
                sel_next = free_way;
            else
                sel_next = rot_reg;
            if (mark_cand > mark_reg)
                mark_next = mark_cand;
        end

        if (cmd.emit)
        begin
            rv_next    = 1'b1;
            way_next   = way_out(sel_reg);
            fblk_next  = blk_reg;
            start_next = '0;
            run_next   = '0;
            hw_next    = mark_reg;
            last_next  = cmd.last;
            case (cmd.act)
                ACT_EVICT:
                begin
                    op_next             = OP_WRITEBACK;
                    fblk_next           = rd_tag;
                    dirty_next[sel_reg] = 1'b0;
                end
                ACT_FILL:
                begin
                    op_next             = OP_FILL;
                    valid_next[sel_reg] = 1'b1;
                    dirty_next[sel_reg] = 1'b0;
                end
                ACT_STORE:
                begin
                    op_next             = OP_STORE;
                    start_next          = fs_reg;
                    run_next            = cnt_eff;
                    dirty_next[sel_reg] = 1'b1;
                    rot_next = (rot_reg == WAY_W'(WAYS - 1)) ? '0 : rot_reg + 1'b1;
                end
                ACT_FULL:
                begin
                    op_next             = OP_WRITEBACK;
                    dirty_next[sel_reg] = 1'b0;
                end
                ACT_FLUSH_WB:
                begin
                    op_next               = OP_WRITEBACK;
                    way_next              = way_out(flush_way);
                    fblk_next             = rd_tag;
                    dirty_next[flush_way] = 1'b0;
                end
                default:
                begin
                    op_next   = OP_DONE;
                    way_next  = '0;
                    fblk_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            rot_reg   <= '0;
            mark_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            rot_reg   <= rot_next;
            mark_reg  <= mark_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            kind_reg <= kind;
            blk_reg  <= block;
            fs_reg   <= first_sector;
            cnt_reg  <= sector_count;
        end
        if (cmd.emit && (cmd.act == ACT_FILL))
            tags_reg[sel_reg] <= blk_reg;
        sel_reg   <= sel_next;
        op_reg    <= op_next;
        way_reg   <= way_next;
        fblk_reg  <= fblk_next;
        start_reg <= start_next;
        run_reg   <= run_next;
        hw_reg    <= hw_next;
        last_reg  <= last_next;
    end

    assign rsp.valid        = rv_reg;
    assign rsp.op           = op_reg;
    assign rsp.way          = way_reg;
    assign rsp.flash_block  = fblk_reg;
    assign rsp.start_sector = start_reg;
    assign rsp.run_length   = run_reg;
    assign rsp.high_water   = hw_reg;
    assign rsp.last         = last_reg;

    // A way can only be dirty while it holds a block.
    a_dirty_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg & ~valid_reg) == '0)
        else $error("dirty way without a valid tag");

    // The controller never overwrites a result that has not been taken.
    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> slot_free)
        else $error("result register overwritten");

    a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (cmd.act == ACT_FILL)) |=> valid_reg[$past(sel_reg)])
        else $error("filled way not marked valid");

    a_mark_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |=> mark_reg >= $past(mark_reg))
        else $error("high-water mark decreased");

endmodule

[src/flash_block_writeback_cache.sv]
// Top level of the flash block write-back cache controller.
// Depends on fbwc_pkg, fbwc_if, fbwc_ctrl and fbwc_datapath.
//
// The block takes one item at a time. An accepted item is latched and then
// looked up in the tags, then produces one result per cycle while the result
// register is free. The controller emits one result from each of the evict,
// fill, store and full states, and from the flush state one per dirty way and
// then the done result. An item dropped at the lookup produces no result.
// A result waits in an output register, so the next item is accepted while
// the last result of the previous one is still waiting.
module flash_block_writeback_cache import fbwc_pkg::*;
#(
    parameter int WAYS              = FBWC_WAYS,
    parameter int NUM_BLOCKS        = FBWC_NUM_BLOCKS,
    parameter int SECTORS_PER_BLOCK = FBWC_SECTORS_PER_BLOCK
)
(
    input  logic        clk,
    input  logic        rst_n,
    fbwc_req_if.sink    req,
    fbwc_rsp_if.source  rsp
);

    ctl_cmd_t   cmd;
    dp_status_t status;
    logic       in_ready;

    assign req.ready = in_ready;

    fbwc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fbwc_datapath
    #(
        .WAYS              (WAYS),
        .NUM_BLOCKS        (NUM_BLOCKS),
        .SECTORS_PER_BLOCK (SECTORS_PER_BLOCK)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .kind         (req.kind),
        .block        (req.block),
        .first_sector (req.first_sector),
        .sector_count (req.sector_count),
        .cmd          (cmd),
        .status       (status),
        .rsp          (rsp)
    );

endmodule

[tb/fbwc_checker.sv]
// Checker for the flash block write-back cache: watches both channels, predicts
// the flash operations of every accepted item and compares each result with them.
// Depends on fbwc_pkg and the channel interfaces in fbwc_if.
module fbwc_checker import fbwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fbwc_req_if         req,
    fbwc_rsp_if         rsp,
    output int unsigned fail_count,
    output int unsigned ops_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        op_t                  op;
        logic [WAY_OUT_W-1:0] way;
        logic [BLOCK_W-1:0]   flash_block;
        logic [SECTOR_W-1:0]  start_sector;
        logic [COUNT_W-1:0]   run_length;
        logic [MARK_W-1:0]    high_water;
        logic                 last;
    } flash_op_t;

    // Operations still owed by the block, oldest first.
    flash_op_t flash_op_q[$];

    // Predicted cache contents.
    logic [BLOCK_W-1:0]   tag_of [FBWC_WAYS];
    logic [FBWC_WAYS-1:0] held;
    logic [FBWC_WAYS-1:0] dirty;
    int                   rr_ptr;
    logic [MARK_W-1:0]    mark;

    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    function automatic flash_op_t make_op(input op_t code, input int w,
                                          input logic [BLOCK_W-1:0] b,
                                          input int s, input int r);
        flash_op_t o;
        o.op           = code;
        o.way          = WAY_OUT_W'(w);
        o.flash_block  = b;
        o.start_sector = SECTOR_W'(s);
        o.run_length   = COUNT_W'(r);
        o.high_water   = '0;
        o.last         = 1'b0;
        return o;
    endfunction

    function automatic string op_text(input flash_op_t o);
        return $sformatf("op=%0d way=%0d block=%0d start=%0d run=%0d high_water=%0d last=%0b",
                         o.op, o.way, o.flash_block, o.start_sector, o.run_length,
                         o.high_water, o.last);
    endfunction

    // Works out the flash operations caused by one item and updates the cache state.
    function automatic void plan_flash_ops(input logic kind, input logic [BLOCK_W-1:0] blk,
                                           input logic [SECTOR_W-1:0] fs,
                                           input logic [COUNT_W-1:0] cnt);
        flash_op_t ops[$];
        int        sel;
        int        run;
        int        sector_end;
        sel = -1;
        if (kind)
        begin
            for (int w = 0; w < FBWC_WAYS; w++)
            begin
                if (held[w] && dirty[w])
                begin
                    ops.push_back(make_op(OP_WRITEBACK, w, tag_of[w], 0, 0));
                    dirty[w] = 1'b0;
                end
            end
            ops.push_back(make_op(OP_DONE, 0, '0, 0, 0));
        end
        else
        begin
            run = int'(cnt);
            if (run > FBWC_SECTORS_PER_BLOCK - int'(fs))
                run = FBWC_SECTORS_PER_BLOCK - int'(fs);
            if (run != 0)
            begin
                for (int w = 0; w < FBWC_WAYS; w++)
                    if (sel < 0 && held[w] && tag_of[w] == blk)
                        sel = w;
                if (sel < 0)
                begin
                    for (int w = 0; w < FBWC_WAYS; w++)
                        if (sel < 0 && !held[w])
                            sel = w;
                    // With every way in use, the round-robin pointer names the victim.
                    if (sel < 0)
                    begin
                        sel = rr_ptr;
                        if (dirty[sel])
                        begin
                            ops.push_back(make_op(OP_WRITEBACK, sel, tag_of[sel], 0, 0));
                            dirty[sel] = 1'b0;
                        end
                    end
                    tag_of[sel] = blk;
                    held[sel]   = 1'b1;
                    dirty[sel]  = 1'b0;
                    ops.push_back(make_op(OP_FILL, sel, blk, 0, 0));
                end
                ops.push_back(make_op(OP_STORE, sel, blk, int'(fs), run));
                dirty[sel] = 1'b1;
                rr_ptr = (rr_ptr + 1) % FBWC_WAYS;
                if (run == FBWC_SECTORS_PER_BLOCK)
                begin
                    ops.push_back(make_op(OP_WRITEBACK, sel, blk, 0, 0));
                    dirty[sel] = 1'b0;
                end
                sector_end = int'(blk) * FBWC_SECTORS_PER_BLOCK + int'(fs) + run;
                if (sector_end > int'(MARK_MAX))
                    sector_end = int'(MARK_MAX);
                if (sector_end > int'(mark))
                    mark = MARK_W'(sector_end);
            end
        end
        foreach (ops[i])
        begin
            ops[i].high_water = mark;
            ops[i].last       = (i == ops.size() - 1);
            flash_op_q.push_back(ops[i]);
        end
    endfunction

    function automatic void check_result();
        flash_op_t got;
        flash_op_t want;
        string     bad;
        got.op           = op_t'(rsp.op);
        got.way          = rsp.way;
        got.flash_block  = rsp.flash_block;
        got.start_sector = rsp.start_sector;
        got.run_length   = rsp.run_length;
        got.high_water   = rsp.high_water;
        got.last         = rsp.last;
        if (flash_op_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] result with nothing expected: %s", $time, op_text(got));
            return;
        end
        want = flash_op_q.pop_front();
        bad  = "";
        if (got.op !== want.op)                     bad = {bad, " op"};
        if (got.way !== want.way)                   bad = {bad, " way"};
        if (got.flash_block !== want.flash_block)   bad = {bad, " flash_block"};
        if (got.start_sector !== want.start_sector) bad = {bad, " start_sector"};
        if (got.run_length !== want.run_length)     bad = {bad, " run_length"};
        if (got.high_water !== want.high_water)     bad = {bad, " high_water"};
        if (got.last !== want.last)                 bad = {bad, " last"};
        if (bad != "")
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("[%0t] result mismatch in%s", $time, bad);
                $display("    expected %s", op_text(want));
                $display("    actual   %s", op_text(got));
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            flash_op_q.delete();
            for (int w = 0; w < FBWC_WAYS; w++)
                tag_of[w] = '0;
            held   = '0;
            dirty  = '0;
            rr_ptr = 0;
            mark   = '0;
        end
        else
        begin
            // A result can never belong to an item accepted at the same edge,
            // so results are checked before the new item is predicted.
            if (rsp.valid && rsp.ready)
                check_result();
            if (req.valid && req.ready)
                plan_flash_ops(req.kind, req.block, req.first_sector, req.sector_count);
        end
        ops_pending = flash_op_q.size();
    end

endmodule

[tb/tb_flash_block_writeback_cache.sv]
// Top of the flash block write-back cache testbench: clock, reset, stimulus and verdict.
// Depends on fbwc_pkg, fbwc_if, the controller RTL and fbwc_checker.
module tb_flash_block_writeback_cache import fbwc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_FLUSH  = 1'b1;
    localparam int   WRITE_ITEMS = 380;
    localparam int   HOT_COUNT   = 12;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   DRAIN_WAIT  = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   steady = 1'b0;
    int unsigned fail_count;
    int unsigned ops_pending;
    int unsigned cycles = 0;

    logic [BLOCK_W-1:0]  hot_blocks [HOT_COUNT];
    logic [BLOCK_W-1:0]  blk;
    logic [SECTOR_W-1:0] fs;
    logic [COUNT_W-1:0]  cnt;
    int                  useful;
    int                  pick;

    fbwc_req_if req_ch ();
    fbwc_rsp_if rsp_ch ();

    flash_block_writeback_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    fbwc_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .ops_pending (ops_pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** flash_block_writeback_cache: FAILED **");
            $finish;
        end
    end

    // Result side stalls at random except during the steady stretch.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 29);
        end
    end

    // Presents one item at a falling edge and holds it until it is accepted.
    task automatic send_item(input logic kind, input logic [BLOCK_W-1:0] b,
                             input logic [SECTOR_W-1:0] s, input logic [COUNT_W-1:0] c);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 29)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.block        <= b;
        req_ch.first_sector <= s;
        req_ch.sector_count <= c;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_WRITE;
        req_ch.block        = '0;
        req_ch.first_sector = '0;
        req_ch.sector_count = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty flush, clipping, extremes, eviction and flushes.
        send_item(KIND_FLUSH, '0, '0, '0);
        send_item(KIND_WRITE, 11'd0, 3'd0, 4'd1);
        send_item(KIND_WRITE, 11'd0, 3'd7, 4'd15);
        send_item(KIND_WRITE, 11'd2047, 3'd0, 4'd8);
        send_item(KIND_WRITE, 11'd5, 3'd3, 4'd0);
        for (int i = 0; i < 6; i++)
            send_item(KIND_WRITE, BLOCK_W'(100 + i), SECTOR_W'(i), COUNT_W'(i + 1));
        // The cache is full now: one clean victim, then a dirty one.
        send_item(KIND_WRITE, 11'd200, 3'd1, 4'd2);
        send_item(KIND_WRITE, 11'd201, 3'd6, 4'd3);
        send_item(KIND_WRITE, 11'd0, 3'd2, 4'd5);
        send_item(KIND_FLUSH, 11'd2047, 3'd7, 4'd15);
        send_item(KIND_FLUSH, '0, '0, '0);
        send_item(KIND_WRITE, 11'd1024, 3'd4, 4'd4);
        send_item(KIND_WRITE, 11'd1024, 3'd0, 4'd8);
        send_item(KIND_WRITE, 11'd1365, 3'd5, 4'd9);

        // Random part: a small pool of blocks gives hits and evictions,
        // with the odd block from the whole range as noise.
        hot_blocks[0] = '0;
        hot_blocks[1] = '1;
        for (int i = 2; i < HOT_COUNT; i++)
            hot_blocks[i] = BLOCK_W'($urandom);
        useful = 0;
        while (useful < WRITE_ITEMS)
        begin
            steady = (useful >= 150 && useful < 240);
            if ($urandom_range(59) == 0)
                hot_blocks[$urandom_range(HOT_COUNT - 1)] = BLOCK_W'($urandom);
            if ($urandom_range(99) < 6)
            begin
                send_item(KIND_FLUSH, BLOCK_W'($urandom), SECTOR_W'($urandom),
                          COUNT_W'($urandom));
                useful++;
            end
            else
            begin
                blk  = ($urandom_range(99) < 85) ? hot_blocks[$urandom_range(HOT_COUNT - 1)]
                                                 : BLOCK_W'($urandom);
                fs   = SECTOR_W'($urandom_range(7));
                pick = $urandom_range(99);
                if (pick < 5)
                begin
                    cnt = '0;
                end
                else if (pick < 15)
                begin
                    fs  = '0;
                    cnt = COUNT_W'(FBWC_SECTORS_PER_BLOCK);
                end
                else if (pick < 25)
                begin
                    cnt = COUNT_W'($urandom_range(15, 9));
                end
                else
                begin
                    cnt = COUNT_W'($urandom_range(8, 1));
                end
                send_item(KIND_WRITE, blk, fs, cnt);
                if (cnt != 0)
                    useful++;
            end
        end
        steady = 1'b0;
        @(negedge clk);
        req_ch.valid <= 1'b0;

        do
            @(negedge clk);
        while (ops_pending != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("** flash_block_writeback_cache: PASSED **");
        else
            $display("** flash_block_writeback_cache: FAILED **");
        $finish;
    end

endmodule
